/* rtl/convolve3x3_divide_clamp_macros.svh */
// assertion helpers shared by the convolution rtl
`ifndef CONVOLVE3X3_DIVIDE_CLAMP_MACROS_SVH
`define CONVOLVE3X3_DIVIDE_CLAMP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define C3DC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define C3DC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/c3dc_pkg.sv */
package c3dc_pkg;

   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int TAPS       = 9;
   localparam int TAP_IDX_W  = 4;
   localparam int ACC_W      = 29;
   localparam int DVD_W      = 28;
   localparam int DIV_STEPS  = DVD_W;
   localparam int STEP_W     = 5;
   localparam int OUT_IDX_W  = 10;
   localparam int SIZE_W     = 11;
   localparam int ROW_REG_W  = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int RSP_DATA_W = 32;
   localparam int PIX_MAX    = 255;
   localparam int PIX_MIN    = 0;
   localparam int MIN_SIZE   = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TOP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_MID    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT      = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MAC,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

/* rtl/convolve3x3_divide_clamp.sv */
// 3x3 convolution of one 8-bit plane in raster order. Each item is one sample; the two
// previous rows sit in a single line memory (upper and lower row side by side in one
// 16-bit word) that is read at the current column and written back in the next cycle,
// and a window of six registers holds the last two columns. Samples in the first two
// rows or columns give no result and pass only through accept and the line memory
// read-modify-write. Every other sample gives the interior pixel one row up and one
// column left: nine signed coefficient-times-sample products summed by one shared
// multiplier, then divided by the divisor (0 acts as 1) with truncation toward zero in
// a one-bit-per-cycle divider of 28 steps, then clamped to 0..255. Such an item passes
// the multiply, prepare, divide and done states; it skips the divider when the sum is
// negative (the result is then 0) and waits in done while rsp_tready stalls the output.
// One item is in flight at a time; a finished result waits in the output register
// while the next item is taken. rsp_tlast marks the last interior pixel of the plane.
// Configuration writes are taken in any cycle (csr_ready is always high) but are meant
// for an idle block; writing image width or height also restarts the plane at row 0,
// column 0. Sizes are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT. Line memory contents
// after reset are unknown; only entries written earlier in the plane reach a result.
module convolve3x3_divide_clamp
   import c3dc_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // input samples
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [7:0] pixel_in
   // filtered results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] pixel_out, [17:8] out_row,
                                              // [27:18] out_col, [31:28] zero
   output logic                  rsp_tlast,   // frame_last
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ROW_REG_W-1:0]  csr_data
);

`include "convolve3x3_divide_clamp_macros.svh"

   // column and row counter widths, and widths wide enough to compare sizes
   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int RW      = $clog2(MAX_HEIGHT);
   localparam int WSZ     = ($clog2(MAX_WIDTH + 1) > SIZE_W) ? $clog2(MAX_WIDTH + 1) : SIZE_W;
   localparam int HSZ     = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ? $clog2(MAX_HEIGHT + 1) : SIZE_W;
   localparam int W_RST   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int H_RST   = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
   localparam int LINE_W  = 2 * PIX_W;

   // fsm
   state_type state_ff, state_in;

   // configuration, sizes kept as last column / last row index
   logic [ROW_REG_W-1:0] coef_top_ff, coef_top_in;
   logic [ROW_REG_W-1:0] coef_mid_ff, coef_mid_in;
   logic [ROW_REG_W-1:0] coef_bot_ff, coef_bot_in;
   logic [PIX_W-1:0]     div_ff, div_in;
   logic [CW-1:0]        w_last_ff, w_last_in;
   logic [RW-1:0]        h_last_ff, h_last_in;

   // raster position of the next sample
   logic [CW-1:0]        col_cnt_ff, col_cnt_in;
   logic [RW-1:0]        row_cnt_ff, row_cnt_in;

   // sample in flight
   logic [CW-1:0]        cur_col_ff, cur_col_in;
   logic [RW-1:0]        cur_row_ff, cur_row_in;
   logic [PIX_W-1:0]     px_ff, px_in;
   logic                 last_ff, last_in;

   // window: [0..2] column c-2 top/mid/bottom, [3..5] column c-1
   logic [PIX_W-1:0]     win_ff [6];
   logic [PIX_W-1:0]     win_in [6];
   logic [PIX_W-1:0]     tap_ff [TAPS];
   logic [PIX_W-1:0]     tap_in [TAPS];

   // multiply-accumulate and divider
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [DVD_W-1:0]         quo_ff, quo_in;
   logic [PIX_W-1:0]         rem_ff, rem_in;
   logic                     neg_ff, neg_in;

   // output register
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tlast_ff, rsp_tlast_in;

   // line memory: [15:8] row r-2, [7:0] row r-1
   logic [LINE_W-1:0] line_mem [MAX_WIDTH];
   logic [LINE_W-1:0] line_rd_ff;

   // fsm outputs
   logic mem_rd;
   logic mem_wr;
   logic rsp_load;

   // datapath helpers
   logic                    req_acc;
   logic                    csr_acc;
   logic                    interior;
   logic [PIX_W-1:0]        top_px;
   logic [PIX_W-1:0]        mid_px;
   logic signed [COEF_W-1:0] coef_arr [TAPS];
   logic signed [COEF_W-1:0] coef_sel;
   logic [PIX_W-1:0]        tap_sel;
   logic signed [COEF_W+PIX_W:0] prod;
   logic [PIX_W-1:0]        div_eff;
   logic [PIX_W:0]          trial;
   logic                    qbit;
   logic [PIX_W-1:0]        pix_res;
   logic [WSZ-1:0]          w_req, w_clamp;
   logic [HSZ-1:0]          h_req, h_clamp;

   // assertion helpers
   logic                    cnt_in_range;
   logic                    plane_end;
   logic                    cnt_at_origin;

   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   assign top_px   = line_rd_ff[LINE_W-1:PIX_W];
   assign mid_px   = line_rd_ff[PIX_W-1:0];
   assign interior = (cur_row_ff >= RW'(2)) && (cur_col_ff >= CW'(2));
   assign div_eff  = (div_ff == '0) ? PIX_W'(1) : div_ff;

   // tap k multiplies coefficient of row k%3 at column position k/3
   for (genvar k = 0; k < TAPS; k++) begin : g_coef
      if (k % 3 == 0) begin : g_top
         assign coef_arr[k] = coef_top_ff[COEF_W*(k/3) +: COEF_W];
      end else if (k % 3 == 1) begin : g_mid
         assign coef_arr[k] = coef_mid_ff[COEF_W*(k/3) +: COEF_W];
      end else begin : g_bot
         assign coef_arr[k] = coef_bot_ff[COEF_W*(k/3) +: COEF_W];
      end
   end

   assign coef_sel = coef_arr[step_ff[TAP_IDX_W-1:0]];
   assign tap_sel  = tap_ff[step_ff[TAP_IDX_W-1:0]];
   assign prod     = coef_sel * $signed({1'b0, tap_sel});

   // restoring divider step: bring in the next dividend bit
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign qbit  = (trial >= {1'b0, div_eff});

   // saturate; a negative sum always ends at zero
   always_comb begin
      if (neg_ff) begin
         pix_res = PIX_W'(PIX_MIN);
      end else if (quo_ff > DVD_W'(PIX_MAX)) begin
         pix_res = PIX_W'(PIX_MAX);
      end else begin
         pix_res = quo_ff[PIX_W-1:0];
      end
   end

   // size clamps
   always_comb begin
      w_req = WSZ'(csr_data[SIZE_W-1:0]);
      h_req = HSZ'(csr_data[SIZE_W-1:0]);
      if (w_req < WSZ'(MIN_SIZE)) begin
         w_clamp = WSZ'(MIN_SIZE);
      end else if (w_req > WSZ'(MAX_WIDTH)) begin
         w_clamp = WSZ'(MAX_WIDTH);
      end else begin
         w_clamp = w_req;
      end
      if (h_req < HSZ'(MIN_SIZE)) begin
         h_clamp = HSZ'(MIN_SIZE);
      end else if (h_req > HSZ'(MAX_HEIGHT)) begin
         h_clamp = HSZ'(MAX_HEIGHT);
      end else begin
         h_clamp = h_req;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = interior ? ST_MAC : ST_IDLE;
         end
         ST_MAC: begin
            if (step_ff == STEP_W'(TAPS - 1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = acc_ff[ACC_W-1] ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fsm outputs
   always_comb begin
      req_tready = 1'b0;
      mem_rd     = 1'b0;
      mem_wr     = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            mem_rd     = req_tvalid;
         end
         ST_FETCH: begin
            mem_wr = 1'b1;
         end
         ST_DONE: begin
            rsp_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      coef_top_in = coef_top_ff;
      coef_mid_in = coef_mid_ff;
      coef_bot_in = coef_bot_ff;
      div_in      = div_ff;
      w_last_in   = w_last_ff;
      h_last_in   = h_last_ff;
      col_cnt_in  = col_cnt_ff;
      row_cnt_in  = row_cnt_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      px_in       = px_ff;
      last_in     = last_ff;
      win_in      = win_ff;
      tap_in      = tap_ff;
      step_in     = step_ff;
      acc_in      = acc_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      neg_in      = neg_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               px_in      = req_tdata;
               cur_col_in = col_cnt_ff;
               cur_row_in = row_cnt_ff;
            end
         end
         ST_FETCH: begin
            // freeze the neighborhood, then shift the window
            for (int i = 0; i < 6; i++) begin
               tap_in[i] = win_ff[i];
            end
            tap_in[6] = top_px;
            tap_in[7] = mid_px;
            tap_in[8] = px_ff;
            win_in[0] = win_ff[3];
            win_in[1] = win_ff[4];
            win_in[2] = win_ff[5];
            win_in[3] = top_px;
            win_in[4] = mid_px;
            win_in[5] = px_ff;
            last_in   = (cur_row_ff == h_last_ff) && (cur_col_ff == w_last_ff);
            step_in   = '0;
            acc_in    = '0;
            if (cur_col_ff == w_last_ff) begin
               col_cnt_in = '0;
               row_cnt_in = (cur_row_ff == h_last_ff) ? '0 : cur_row_ff + RW'(1);
            end else begin
               col_cnt_in = cur_col_ff + CW'(1);
               row_cnt_in = cur_row_ff;
            end
         end
         ST_MAC: begin
            acc_in  = acc_ff + ACC_W'(prod);
            step_in = step_ff + STEP_W'(1);
         end
         ST_PREP: begin
            quo_in  = acc_ff[DVD_W-1:0];
            rem_in  = '0;
            step_in = '0;
            neg_in  = acc_ff[ACC_W-1];
         end
         ST_DIV: begin
            rem_in  = qbit ? PIX_W'(trial - {1'b0, div_eff}) : trial[PIX_W-1:0];
            quo_in  = {quo_ff[DVD_W-2:0], qbit};
            step_in = step_ff + STEP_W'(1);
         end
         default: begin
            step_in = step_ff;
         end
      endcase

      if (csr_acc) begin
         case (csr_index)
            CSR_COEF_TOP:    coef_top_in = csr_data;
            CSR_COEF_MID:    coef_mid_in = csr_data;
            CSR_COEF_BOTTOM: coef_bot_in = csr_data;
            CSR_DIVISOR:     div_in      = csr_data[PIX_W-1:0];
            CSR_WIDTH: begin
               w_last_in  = CW'(w_clamp - WSZ'(1));
               col_cnt_in = '0;
               row_cnt_in = '0;
            end
            CSR_HEIGHT: begin
               h_last_in  = RW'(h_clamp - HSZ'(1));
               col_cnt_in = '0;
               row_cnt_in = '0;
            end
            default: begin
               div_in = div_ff;
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_DATA_W'({OUT_IDX_W'(cur_col_ff - CW'(1)),
                                      OUT_IDX_W'(cur_row_ff - RW'(1)),
                                      pix_res});
         rsp_tlast_in  = last_ff;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         coef_top_ff   <= '0;
         coef_mid_ff   <= ROW_REG_W'(65536);
         coef_bot_ff   <= '0;
         div_ff        <= PIX_W'(1);
         w_last_ff     <= CW'(W_RST - 1);
         h_last_ff     <= RW'(H_RST - 1);
         col_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         coef_top_ff   <= coef_top_in;
         coef_mid_ff   <= coef_mid_in;
         coef_bot_ff   <= coef_bot_in;
         div_ff        <= div_in;
         w_last_ff     <= w_last_in;
         h_last_ff     <= h_last_in;
         col_cnt_ff    <= col_cnt_in;
         row_cnt_ff    <= row_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         win_ff        <= win_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_col_ff   <= cur_col_in;
      cur_row_ff   <= cur_row_in;
      px_ff        <= px_in;
      last_ff      <= last_in;
      tap_ff       <= tap_in;
      step_ff      <= step_in;
      acc_ff       <= acc_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      neg_ff       <= neg_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   // line memory: read at accept, older row shifted up on write-back
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[cur_col_ff] <= {mid_px, px_ff};
      end
      if (mem_rd) begin
         line_rd_ff <= line_mem[col_cnt_ff];
      end
   end

   // counters in range; last sample of a plane at write-back, no register write beside it; origin
   assign cnt_in_range  = (col_cnt_ff <= w_last_ff) && (row_cnt_ff <= h_last_ff);
   assign plane_end     = (state_ff == ST_FETCH) && (cur_row_ff == h_last_ff) &&
                          (cur_col_ff == w_last_ff) && !csr_valid;
   assign cnt_at_origin = (col_cnt_ff == '0) && (row_cnt_ff == '0);

   // the partial remainder always stays below the divisor
   `C3DC_ASSERT_IMP(a_div_rem, state_ff == ST_DIV, rem_ff < div_eff, "divider remainder overflow")
   // raster counters never pass the configured width or height
   `C3DC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_in_range, "raster counter out of range")
   // a result only appears after the done state
   `C3DC_ASSERT_IMP(a_rsp_src, $rose(rsp_tvalid_ff), $past(state_ff) == ST_DONE, "bad result load")
   // the last sample of a plane wraps both counters
   `C3DC_ASSERT_NXT(a_plane_wrap, plane_end, cnt_at_origin, "plane end did not wrap counters")

endmodule

/* tb/sv/tb_convolve3x3_divide_clamp.sv */
module tb_convolve3x3_divide_clamp;
   import c3dc_pkg::*;

   localparam int MAX_DIM       = 1024;
   localparam int RANDOM_ITEMS  = 700;
   localparam int WIDE_W        = 120;
   localparam int WIDE_PLANE    = 3 * WIDE_W;    // one full plane, height clamped up to 3
   localparam int TALL_FEED     = 300;           // first rows of a clamped tall plane
   localparam int TALL_HOLD_AT  = 150;
   localparam int SETTLE_CYCLES = 60;            // room for the longest item to finish, plus slack
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int IDLE_PERCENT  = 28;
   localparam int LONG_HOLD     = 300;

   // indexes the block has no register behind
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [15:0] TAP_EXTREMES [4] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001};

   // one full 3x4 plane, then the first nine samples of the next one
   localparam logic [PIX_W-1:0] DIRECTED_PIXELS [21] = '{
      8'd0,   8'd255, 8'd255,
      8'd255, 8'd0,   8'd255,
      8'd0,   8'd255, 8'd128,
      8'd1,   8'd254, 8'd0,
      8'd255, 8'd255, 8'd255, 8'd0,
      8'd7,   8'd255, 8'd0,   8'd128, 8'd255
   };

   typedef struct packed {
      logic                 last;
      logic [OUT_IDX_W-1:0] col;
      logic [OUT_IDX_W-1:0] row;
      logic [PIX_W-1:0]     value;
   } pixel_result_type;

   // tracks the window and line stores and queues the filtered pixels to come
   class filtered_pixel_board;
      logic [ROW_REG_W-1:0] coef_rows [3];
      logic [7:0]           divisor;
      logic [SIZE_W-1:0]    width_reg;
      logic [SIZE_W-1:0]    height_reg;
      logic [PIX_W-1:0]     line_upper [MAX_DIM];
      logic [PIX_W-1:0]     line_lower [MAX_DIM];
      logic [PIX_W-1:0]     win [6];   // [0..2] column c-2 top..bottom, [3..5] column c-1
      int unsigned          col_cnt;
      int unsigned          row_cnt;
      pixel_result_type     expected_pixels [$];
      int                   mismatches;
      int                   checked;

      function new();
         coef_rows[0] = '0;
         coef_rows[1] = 48'h0000_0001_0000;
         coef_rows[2] = '0;
         divisor      = 8'd1;
         width_reg    = SIZE_W'(MAX_DIM);
         height_reg   = SIZE_W'(MAX_DIM);
         foreach (line_upper[i]) begin
            line_upper[i] = '0;
            line_lower[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         col_cnt    = 0;
         row_cnt    = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function int unsigned clamp_size(logic [SIZE_W-1:0] v);
         if (v < MIN_SIZE) return MIN_SIZE;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      function void note_write(logic [CSR_IDX_W-1:0] idx, logic [ROW_REG_W-1:0] data);
         case (idx)
            CSR_COEF_TOP:    coef_rows[0] = data;
            CSR_COEF_MID:    coef_rows[1] = data;
            CSR_COEF_BOTTOM: coef_rows[2] = data;
            CSR_DIVISOR:     divisor = data[7:0];
            CSR_WIDTH: begin
               width_reg = data[SIZE_W-1:0];
               col_cnt   = 0;
               row_cnt   = 0;
            end
            CSR_HEIGHT: begin
               height_reg = data[SIZE_W-1:0];
               col_cnt    = 0;
               row_cnt    = 0;
            end
            default: ;
         endcase
      endfunction

      function void take_sample(logic [PIX_W-1:0] px);
         int unsigned      w, h, c, r;
         logic [PIX_W-1:0] column [3][3];   // [left..right][top..bottom]
         int               sum, tap, quot, dv;
         pixel_result_type res;
         w = clamp_size(width_reg);
         h = clamp_size(height_reg);
         c = col_cnt;
         r = row_cnt;
         if (c >= w) c = w - 1;
         if (r >= h) r = h - 1;
         column[0] = '{win[0], win[1], win[2]};
         column[1] = '{win[3], win[4], win[5]};
         column[2] = '{line_upper[c], line_lower[c], px};
         line_upper[c] = line_lower[c];
         line_lower[c] = px;
         if (r >= 2 && c >= 2) begin
            sum = 0;
            for (int p = 0; p < 3; p++) begin
               for (int k = 0; k < 3; k++) begin
                  tap = $signed(coef_rows[k][16*p +: 16]);
                  sum += tap * int'(column[p][k]);
               end
            end
            dv   = (divisor == 8'd0) ? 1 : int'(divisor);
            quot = sum / dv;   // truncates toward zero
            if (quot < PIX_MIN) res.value = PIX_MIN;
            else if (quot > PIX_MAX) res.value = PIX_MAX;
            else res.value = quot[PIX_W-1:0];
            res.row  = OUT_IDX_W'(r - 1);
            res.col  = OUT_IDX_W'(c - 1);
            res.last = (r == h - 1) && (c == w - 1);
            expected_pixels.push_back(res);
         end
         win[0] = win[3];
         win[1] = win[4];
         win[2] = win[5];
         win[3] = column[2][0];
         win[4] = column[2][1];
         win[5] = column[2][2];
         if (c == w - 1) begin
            col_cnt = 0;
            row_cnt = (r == h - 1) ? 0 : r + 1;
         end else begin
            col_cnt = c + 1;
            row_cnt = r;
         end
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_pixel(logic [RSP_DATA_W-1:0] data, logic last);
         pixel_result_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: pixel %0d at row %0d col %0d arrived with nothing pending",
                     $time, data[7:0], data[17:8], data[27:18]);
            return;
         end
         want = expected_pixels.pop_front();
         checked++;
         compare_field("pixel_out", want.value, data[7:0]);
         compare_field("out_row", want.row, data[17:8]);
         compare_field("out_col", want.col, data[27:18]);
         compare_field("pad bits", 0, data[31:28]);
         compare_field("frame_last", want.last, last);
      endfunction
   endclass

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata   = '0;   // [7:0] pixel_in
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [7:0] pixel_out, [17:8] out_row,
                                              // [27:18] out_col, [31:28] zero
   logic                  rsp_tlast;          // frame_last
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [ROW_REG_W-1:0]  csr_data    = '0;

   filtered_pixel_board board = new();

   // idle switches for each side, set per phase by the stimulus
   bit tx_idles = 1'b1;
   bit rx_idles = 1'b1;
   // the stimulus bumps this to ask the receiver for one long hold-off
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int samples_fed   = 0;
   int reg_writes    = 0;

   convolve3x3_divide_clamp #(
      .MAX_WIDTH  (MAX_DIM),
      .MAX_HEIGHT (MAX_DIM)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side: check every accepted item, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_pixel(rsp_tdata, rsp_tlast);
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         // long back-pressure so the block fills up and stalls its input
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= !(rx_idles && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped after %0d cycles", CYCLE_LIMIT);
      $display("FAIL convolve3x3_divide_clamp");
      $finish;
   end

   // one register write; valid drops for a cycle so the next write starts clean
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [ROW_REG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.note_write(idx, data);
      reg_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // offer one sample, with random idle cycles ahead of it
   task automatic send_pixel(logic [PIX_W-1:0] px);
      while (tx_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      board.take_sample(px);
      samples_fed++;
   endtask

   // sender pause: all pending pixels out, then let any border item finish
   task automatic wait_drained();
      while (board.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return PIX_W'($urandom());
   endfunction

   // full-range, small blur-like or extreme taps
   function automatic logic [ROW_REG_W-1:0] random_row();
      logic [ROW_REG_W-1:0] row;
      int                   pick;
      pick = $urandom_range(2);
      for (int p = 0; p < 3; p++) begin
         case (pick)
            0:       row[16*p +: 16] = 16'($urandom());
            1:       row[16*p +: 16] = 16'($urandom_range(8) - 4);
            default: row[16*p +: 16] = TAP_EXTREMES[$urandom_range(3)];
         endcase
      end
      return row;
   endfunction

   // size write with junk above the 11 register bits
   task automatic write_size(logic [CSR_IDX_W-1:0] idx, int unsigned size);
      logic [ROW_REG_W-1:0] noisy;
      noisy = {16'($urandom()), $urandom()};
      noisy[SIZE_W-1:0] = SIZE_W'(size);
      write_reg(idx, noisy);
   endtask

   task automatic feed_random(int count, int hold_at);
      for (int k = 0; k < count; k++) begin
         if (k == hold_at) hold_requests++;
         send_pixel(random_pixel());
      end
      req_tvalid <= 1'b0;
   endtask

   // new random settings for one phase; sizes mostly small so planes finish
   task automatic shuffle_settings();
      int                   pick;
      int unsigned          size;
      logic [ROW_REG_W-1:0] noisy;
      if ($urandom_range(9) < 6) begin
         pick = $urandom_range(19);
         if (pick < 14) size = $urandom_range(MIN_SIZE, 12);
         else if (pick < 16) size = $urandom_range(MIN_SIZE - 1);
         else if (pick < 19) size = $urandom_range(13, 40);
         else size = $urandom_range(MAX_DIM + 1, 2047);
         write_size(CSR_WIDTH, size);
      end
      if ($urandom_range(9) < 6) begin
         pick = $urandom_range(19);
         if (pick < 14) size = $urandom_range(MIN_SIZE, 8);
         else if (pick < 17) size = $urandom_range(MIN_SIZE - 1);
         else if (pick < 19) size = $urandom_range(9, 20);
         else size = $urandom_range(MAX_DIM + 1, 2047);
         write_size(CSR_HEIGHT, size);
      end
      if ($urandom_range(1) == 0) write_reg(CSR_COEF_TOP, random_row());
      if ($urandom_range(1) == 0) write_reg(CSR_COEF_MID, random_row());
      if ($urandom_range(1) == 0) write_reg(CSR_COEF_BOTTOM, random_row());
      if ($urandom_range(1) == 0) begin
         noisy = {16'($urandom()), $urandom()};
         case ($urandom_range(5))
            0:       noisy[7:0] = 8'd0;
            1:       noisy[7:0] = 8'd1;
            2:       noisy[7:0] = 8'd255;
            3:       noisy[7:0] = 8'($urandom());
            default: noisy[7:0] = 8'($urandom_range(1, 16));
         endcase
         write_reg(CSR_DIVISOR, noisy);
      end
      if ($urandom_range(9) == 0) begin
         write_reg($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                   {16'($urandom()), $urandom()});
      end
   endtask

   initial begin
      int random_fed;
      int burst;
      int big_fed;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme taps, divisor zero, width below the minimum
      write_reg(CSR_COEF_TOP, {16'h0001, 16'h8000, 16'h7FFF});
      write_reg(CSR_COEF_MID, {16'hFFFF, 16'h0004, 16'h0003});
      write_reg(CSR_COEF_BOTTOM, {16'h0010, 16'hFFF0, 16'h0002});
      write_reg(CSR_DIVISOR, 48'hFFFF_FFFF_FF00);
      write_reg(CSR_WIDTH, 48'hFFFF_FFFF_F802);
      write_reg(CSR_HEIGHT, 48'd4);
      // full 3x4 plane ends with frame_last, then the next plane begins
      for (int i = 0; i < 16; i++) send_pixel(DIRECTED_PIXELS[i]);
      req_tvalid <= 1'b0;
      wait_drained();
      // taps and divisor change partway through the plane
      write_reg(CSR_DIVISOR, 48'd255);
      write_reg(CSR_COEF_MID, {16'h0000, 16'h7FFF, 16'h0000});
      for (int i = 16; i < 21; i++) send_pixel(DIRECTED_PIXELS[i]);
      req_tvalid <= 1'b0;
      wait_drained();
      // height written in the middle of a plane restarts it
      write_reg(CSR_HEIGHT, 48'd3);

      // random phases, each ending with the sender paused until drained
      random_fed = 0;
      while (random_fed < RANDOM_ITEMS) begin
         shuffle_settings();
         tx_idles = ($urandom_range(9) != 0);
         rx_idles = ($urandom_range(9) != 0);
         burst = $urandom_range(8, 120);
         feed_random(burst, -1);
         random_fed += burst;
         wait_drained();
      end

      // one whole wide plane (height clamped up), no idling at all
      tx_idles = 1'b0;
      rx_idles = 1'b0;
      write_size(CSR_WIDTH, WIDE_W);
      write_size(CSR_HEIGHT, 0);
      write_reg(CSR_COEF_TOP, random_row());
      write_reg(CSR_COEF_MID, random_row());
      write_reg(CSR_COEF_BOTTOM, random_row());
      write_reg(CSR_DIVISOR, 48'($urandom_range(1, 255)));
      feed_random(WIDE_PLANE, -1);
      wait_drained();

      // tall plane (width clamped up, height clamped down) with idling back on
      // and one long receiver hold-off partway through
      tx_idles = 1'b1;
      rx_idles = 1'b1;
      write_size(CSR_WIDTH, 1);
      write_size(CSR_HEIGHT, 1500);
      write_reg(CSR_COEF_MID, random_row());
      write_reg(CSR_DIVISOR, 48'($urandom_range(1, 64)));
      feed_random(TALL_FEED, TALL_HOLD_AT);
      big_fed = WIDE_PLANE + TALL_FEED;
      wait_drained();

      $display("fed %0d samples (%0d random, %0d in the wide and tall planes), %0d reg writes",
               samples_fed, random_fed, big_fed, reg_writes);
      $display("checked %0d filtered pixels, %0d mismatches, %0d left pending",
               board.checked, board.mismatches, board.expected_pixels.size());
      if (board.mismatches == 0 && board.expected_pixels.size() == 0) begin
         $display("PASS convolve3x3_divide_clamp");
      end else begin
         $display("FAIL convolve3x3_divide_clamp");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/c3dc_pkg.sv
rtl/convolve3x3_divide_clamp.sv
tb/sv/tb_convolve3x3_divide_clamp.sv
